FILE: sv/tbw_pkg.sv
// Shared widths, constants and payload types of the barycentric weight block.
package tbw_pkg;

   localparam int W_COORD = 24;
   localparam int W_DIFF = W_COORD + 1;
   localparam int W_PROD = 2 * W_DIFF;
   localparam int W_AREA = W_PROD + 1;
   localparam int W_MAG = W_AREA - 1;
   localparam int W_WEIGHT = 20;
   localparam int WEIGHT_FRAC_BITS = 16;
   // Quotient keeps one bit below the weight LSB for rounding.
   localparam int Q_BITS = W_WEIGHT;
   localparam int DIV_SHIFT = W_WEIGHT - WEIGHT_FRAC_BITS - 1;
   localparam int W_REM = W_MAG + DIV_SHIFT + 1;
   localparam int DIV_STAGES = Q_BITS + 1;

   localparam logic signed [W_WEIGHT-1:0] WEIGHT_MAX = {1'b0, {(W_WEIGHT-1){1'b1}}};
   localparam logic signed [W_WEIGHT-1:0] WEIGHT_MIN = {1'b1, {(W_WEIGHT-1){1'b0}}};
   localparam logic signed [W_WEIGHT-1:0] WEIGHT_UNIT = W_WEIGHT'(1 << WEIGHT_FRAC_BITS);

   typedef struct packed {
      logic signed [W_COORD-1:0] v0_x;
      logic signed [W_COORD-1:0] v0_y;
      logic signed [W_COORD-1:0] v1_x;
      logic signed [W_COORD-1:0] v1_y;
      logic signed [W_COORD-1:0] v2_x;
      logic signed [W_COORD-1:0] v2_y;
      logic signed [W_COORD-1:0] point_x;
      logic signed [W_COORD-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [W_WEIGHT-1:0] weight_zero;
      logic signed [W_WEIGHT-1:0] weight_one;
      logic signed [W_WEIGHT-1:0] weight_two;
      logic                       degenerate;
   } rsp_type;

   // Magnitudes and signs handed from the front end to the divider.
   typedef struct packed {
      logic [2:0][W_MAG-1:0] num_mag;
      logic [2:0]            neg;
      logic [W_MAG-1:0]      den_mag;
      logic                  degen;
      logic                  on_v0;
   } front_type;

   typedef struct packed {
      logic [W_REM-1:0]  rem;
      logic [Q_BITS-1:0] quo;
      logic              neg;
      logic              sat;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]   lane;
      logic [W_REM-1:0] dvs;
      logic             degen;
      logic             on_v0;
   } div_type;

endpackage

FILE: sv/tbw_ifs.sv
// Valid/ready channel interfaces for sample requests and weight responses.
interface tbw_req_if;
   logic valid;
   logic ready;
   logic signed [tbw_pkg::W_COORD-1:0] v0_x;
   logic signed [tbw_pkg::W_COORD-1:0] v0_y;
   logic signed [tbw_pkg::W_COORD-1:0] v1_x;
   logic signed [tbw_pkg::W_COORD-1:0] v1_y;
   logic signed [tbw_pkg::W_COORD-1:0] v2_x;
   logic signed [tbw_pkg::W_COORD-1:0] v2_y;
   logic signed [tbw_pkg::W_COORD-1:0] point_x;
   logic signed [tbw_pkg::W_COORD-1:0] point_y;
   modport source (output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, point_x, point_y,
                   input ready);
   modport sink (input valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, point_x, point_y,
                 output ready);
endinterface

interface tbw_rsp_if;
   logic valid;
   logic ready;
   logic signed [tbw_pkg::W_WEIGHT-1:0] weight_zero;
   logic signed [tbw_pkg::W_WEIGHT-1:0] weight_one;
   logic signed [tbw_pkg::W_WEIGHT-1:0] weight_two;
   logic degenerate;
   modport source (output valid, weight_zero, weight_one, weight_two, degenerate,
                   input ready);
   modport sink (input valid, weight_zero, weight_one, weight_two, degenerate,
                 output ready);
endinterface

FILE: sv/triangle_barycentric_weights.sv
// Top level of the barycentric weight pipeline for screen-space triangles.
//
// A sample request carries the three triangle vertices and a point, all signed Q16.8.
// The response carries three signed Q4.16 weights, rounded to nearest with ties away
// from zero and saturated, plus a degenerate flag for a zero-area triangle, in which
// case the weights are zero. A point exactly on vertex 0 always yields (1,0,0).
// Both channels use valid/ready; a transfer happens on a clock edge with both high.
// Unless the receiver stalls it, the block takes one transfer per cycle and returns results in request order.
// An item passes 26 registers: four front stages (differences, products, cross
// products, magnitudes), twenty-one divider stages (an overflow check, then one
// quotient bit each for three lanes) and the output register. The response is valid
// once the item reaches the output register and transfers when the
// receiver is ready. Each stage holds its item while the next one is full and stalled,
// so when the receiver drops ready the pipeline fills its empty slots and then backs
// up to the request side; nothing is lost or repeated. A synchronous reset clears
// all valid bits; no item survives reset.
module triangle_barycentric_weights (
   input logic          clock,
   input logic          reset,
   tbw_req_if.sink      req_chan,
   tbw_rsp_if.source    rsp_chan
);

   tbw_pkg::req_type   req_data;
   tbw_pkg::front_type front_data;
   tbw_pkg::div_type   div_data;
   tbw_pkg::rsp_type   rsp_data;
   logic front_valid, front_ready;
   logic div_valid, div_ready;

   // Gather the request payload into one word for the front end.
   assign req_data.v0_x = req_chan.v0_x;
   assign req_data.v0_y = req_chan.v0_y;
   assign req_data.v1_x = req_chan.v1_x;
   assign req_data.v1_y = req_chan.v1_y;
   assign req_data.v2_x = req_chan.v2_x;
   assign req_data.v2_y = req_chan.v2_y;
   assign req_data.point_x = req_chan.point_x;
   assign req_data.point_y = req_chan.point_y;

   tbw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // The divider produces one extra quotient bit that the output stage rounds away.
   tbw_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   tbw_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.weight_zero = rsp_data.weight_zero;
   assign rsp_chan.weight_one = rsp_data.weight_one;
   assign rsp_chan.weight_two = rsp_data.weight_two;
   assign rsp_chan.degenerate = rsp_data.degenerate;

endmodule

FILE: sv/tbw_front.sv
// Front end: differences, products, cross products and magnitudes in four stages.
module tbw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tbw_pkg::req_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tbw_pkg::front_type   out_data
);

   logic [3:0] valid_ff;
   logic [4:0] go;

   // Stage 1: coordinate differences.
   logic signed [tbw_pkg::W_DIFF-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, dpx_ff, dpy_ff;
   logic signed [tbw_pkg::W_DIFF-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic on_v0_1_ff;
   // Stage 2: products.
   logic signed [tbw_pkg::W_PROD-1:0] pa0_ff, pa1_ff, pn0a_ff, pn0b_ff;
   logic signed [tbw_pkg::W_PROD-1:0] pn1a_ff, pn1b_ff, pn2a_ff, pn2b_ff;
   logic on_v0_2_ff;
   // Stage 3: signed areas.
   logic signed [tbw_pkg::W_AREA-1:0] area_ff, n0_ff, n1_ff, n2_ff;
   logic on_v0_3_ff;
   // Stage 4: magnitudes and signs.
   tbw_pkg::front_type out_ff;

   always_comb begin
      go[4] = out_ready;
      for (int k = 3; k >= 0; k--) begin
         go[k] = ~valid_ff[k] | go[k+1];
      end
   end

   assign in_ready = go[0];
   assign out_valid = valid_ff[3];
   assign out_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < 4; k++) begin
            if (go[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         dx1_ff <= tbw_pkg::W_DIFF'(in_data.v1_x) - tbw_pkg::W_DIFF'(in_data.v0_x);
         dy1_ff <= tbw_pkg::W_DIFF'(in_data.v1_y) - tbw_pkg::W_DIFF'(in_data.v0_y);
         dx2_ff <= tbw_pkg::W_DIFF'(in_data.v2_x) - tbw_pkg::W_DIFF'(in_data.v0_x);
         dy2_ff <= tbw_pkg::W_DIFF'(in_data.v2_y) - tbw_pkg::W_DIFF'(in_data.v0_y);
         dpx_ff <= tbw_pkg::W_DIFF'(in_data.point_x) - tbw_pkg::W_DIFF'(in_data.v0_x);
         dpy_ff <= tbw_pkg::W_DIFF'(in_data.point_y) - tbw_pkg::W_DIFF'(in_data.v0_y);
         ax_ff  <= tbw_pkg::W_DIFF'(in_data.v1_x) - tbw_pkg::W_DIFF'(in_data.point_x);
         ay_ff  <= tbw_pkg::W_DIFF'(in_data.v1_y) - tbw_pkg::W_DIFF'(in_data.point_y);
         bx_ff  <= tbw_pkg::W_DIFF'(in_data.v2_x) - tbw_pkg::W_DIFF'(in_data.point_x);
         by_ff  <= tbw_pkg::W_DIFF'(in_data.v2_y) - tbw_pkg::W_DIFF'(in_data.point_y);
         on_v0_1_ff <= (in_data.point_x == in_data.v0_x) && (in_data.point_y == in_data.v0_y);
      end
      if (go[1]) begin
         pa0_ff  <= dx1_ff * dy2_ff;
         pa1_ff  <= dx2_ff * dy1_ff;
         pn0a_ff <= ax_ff * by_ff;
         pn0b_ff <= bx_ff * ay_ff;
         pn1a_ff <= dpx_ff * dy2_ff;
         pn1b_ff <= dx2_ff * dpy_ff;
         pn2a_ff <= dx1_ff * dpy_ff;
         pn2b_ff <= dpx_ff * dy1_ff;
         on_v0_2_ff <= on_v0_1_ff;
      end
      if (go[2]) begin
         area_ff <= tbw_pkg::W_AREA'(pa0_ff) - tbw_pkg::W_AREA'(pa1_ff);
         n0_ff   <= tbw_pkg::W_AREA'(pn0a_ff) - tbw_pkg::W_AREA'(pn0b_ff);
         n1_ff   <= tbw_pkg::W_AREA'(pn1a_ff) - tbw_pkg::W_AREA'(pn1b_ff);
         n2_ff   <= tbw_pkg::W_AREA'(pn2a_ff) - tbw_pkg::W_AREA'(pn2b_ff);
         on_v0_3_ff <= on_v0_2_ff;
      end
      if (go[3]) begin
         out_ff.den_mag <= tbw_pkg::W_MAG'(area_ff[tbw_pkg::W_AREA-1] ? -area_ff : area_ff);
         out_ff.num_mag[0] <= tbw_pkg::W_MAG'(n0_ff[tbw_pkg::W_AREA-1] ? -n0_ff : n0_ff);
         out_ff.num_mag[1] <= tbw_pkg::W_MAG'(n1_ff[tbw_pkg::W_AREA-1] ? -n1_ff : n1_ff);
         out_ff.num_mag[2] <= tbw_pkg::W_MAG'(n2_ff[tbw_pkg::W_AREA-1] ? -n2_ff : n2_ff);
         out_ff.neg[0] <= n0_ff[tbw_pkg::W_AREA-1] ^ area_ff[tbw_pkg::W_AREA-1];
         out_ff.neg[1] <= n1_ff[tbw_pkg::W_AREA-1] ^ area_ff[tbw_pkg::W_AREA-1];
         out_ff.neg[2] <= n2_ff[tbw_pkg::W_AREA-1] ^ area_ff[tbw_pkg::W_AREA-1];
         out_ff.degen <= (area_ff == '0);
         out_ff.on_v0 <= on_v0_3_ff;
      end
   end

endmodule

FILE: sv/tbw_divider.sv
// Pipelined restoring divider: one overflow check stage, then one quotient bit per stage.
module tbw_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tbw_pkg::front_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tbw_pkg::div_type     out_data
);

   localparam int N = tbw_pkg::DIV_STAGES;

   logic [N-1:0] valid_ff;
   logic [N:0] go;
   tbw_pkg::div_type stage_ff [N];
   tbw_pkg::div_type stage_in [N];

   always_comb begin
      go[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         go[k] = ~valid_ff[k] | go[k+1];
      end
   end

   assign in_ready = go[0];
   assign out_valid = valid_ff[N-1];
   assign out_data = stage_ff[N-1];

   // The divisor is scaled so that a numerator below it gives a quotient that fits.
   always_comb begin
      stage_in[0].dvs = tbw_pkg::W_REM'({in_data.den_mag, {tbw_pkg::DIV_SHIFT{1'b0}}});
      stage_in[0].degen = in_data.degen;
      stage_in[0].on_v0 = in_data.on_v0;
      for (int j = 0; j < 3; j++) begin
         stage_in[0].lane[j].rem = tbw_pkg::W_REM'(in_data.num_mag[j]);
         stage_in[0].lane[j].quo = '0;
         stage_in[0].lane[j].neg = in_data.neg[j];
         stage_in[0].lane[j].sat = tbw_pkg::W_REM'(in_data.num_mag[j]) >= stage_in[0].dvs;
      end
   end

   for (genvar k = 1; k < N; k++) begin : g_step
      logic [2:0][tbw_pkg::W_REM-1:0] twice;
      always_comb begin
         stage_in[k] = stage_ff[k-1];
         for (int j = 0; j < 3; j++) begin
            twice[j] = {stage_ff[k-1].lane[j].rem[tbw_pkg::W_REM-2:0], 1'b0};
            if (twice[j] >= stage_ff[k-1].dvs) begin
               stage_in[k].lane[j].rem = twice[j] - stage_ff[k-1].dvs;
               stage_in[k].lane[j].quo = {stage_ff[k-1].lane[j].quo[tbw_pkg::Q_BITS-2:0], 1'b1};
            end else begin
               stage_in[k].lane[j].rem = twice[j];
               stage_in[k].lane[j].quo = {stage_ff[k-1].lane[j].quo[tbw_pkg::Q_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < N; k++) begin
            if (go[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (go[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

endmodule

FILE: sv/tbw_round.sv
// Output stage: rounding, sign, saturation and the special cases, held for the receiver.
module tbw_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tbw_pkg::div_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output tbw_pkg::rsp_type   out_data
);

   logic valid_ff;
   logic go;
   tbw_pkg::rsp_type out_ff;
   tbw_pkg::rsp_type out_in;
   logic [2:0][tbw_pkg::W_WEIGHT-1:0] w;

   assign go = ~valid_ff | out_ready;
   assign in_ready = go;
   assign out_valid = valid_ff;
   assign out_data = out_ff;

   always_comb begin
      logic [tbw_pkg::Q_BITS:0] sum;
      logic [tbw_pkg::W_WEIGHT-1:0] mag;
      for (int j = 0; j < 3; j++) begin
         // Round half away from zero on the magnitude, then apply the sign.
         sum = (tbw_pkg::Q_BITS + 1)'(in_data.lane[j].quo) + 1'b1;
         mag = tbw_pkg::W_WEIGHT'(sum[tbw_pkg::Q_BITS:1]);
         if (in_data.lane[j].neg) begin
            w[j] = in_data.lane[j].sat ? tbw_pkg::WEIGHT_MIN : (~mag + 1'b1);
         end else begin
            w[j] = (in_data.lane[j].sat || mag[tbw_pkg::W_WEIGHT-1]) ?
                   tbw_pkg::WEIGHT_MAX : mag;
         end
      end
      if (in_data.on_v0) begin
         out_in.weight_zero = tbw_pkg::WEIGHT_UNIT;
         out_in.weight_one = '0;
         out_in.weight_two = '0;
         out_in.degenerate = 1'b0;
      end else if (in_data.degen) begin
         out_in.weight_zero = '0;
         out_in.weight_one = '0;
         out_in.weight_two = '0;
         out_in.degenerate = 1'b1;
      end else begin
         out_in.weight_zero = w[0];
         out_in.weight_one = w[1];
         out_in.weight_two = w[2];
         out_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (go) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: tb/tbw_tb_ifs.sv
// Constants used by the testbench.
`timescale 1ns / 1ps
package tbw_tb_pkg;
   localparam int PIPE_LATENCY = 26;
endpackage

FILE: tb/testbench.sv
// Testbench for the barycentric weight block: directed and random samples checked
// against an in-bench predictor of the weights and the degenerate flag.
`timescale 1ns / 1ps
module testbench;

   logic clock;
   logic reset;
   tbw_req_if req_chan ();
   tbw_rsp_if rsp_chan ();

   triangle_barycentric_weights u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   localparam longint CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_LENGTH = 80;

   tbw_pkg::rsp_type expected_weights[$];
   int         error_count = 0;
   longint     cycle_count = 0;
   bit         idle_enable = 1'b1;
   int         hold_off_requests = 0;
   int         hold_off_served = 0;
   int         hold_off_cycles = 0;
   int         stall_left = 0;

   // Clock generation with a 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Rounded ratio n * 2^16 / d, ties away from zero, saturated to 20 bits.
   // Exact long division fits comfortably in 128 bits.
   function automatic logic signed [tbw_pkg::W_WEIGHT-1:0] weight_ratio(longint n, longint d);
      logic [127:0] num_mag;
      logic [127:0] den_mag;
      logic [127:0] quot;
      logic [127:0] rmd;
      bit           negative;
      longint       value;
      negative = (n < 0) != (d < 0);
      num_mag  = (n < 0) ? 128'(-n) : 128'(n);
      den_mag  = (d < 0) ? 128'(-d) : 128'(d);
      num_mag  = num_mag << tbw_pkg::WEIGHT_FRAC_BITS;
      quot     = num_mag / den_mag;
      rmd      = num_mag % den_mag;
      if ((rmd << 1) >= den_mag) quot = quot + 1;
      if (quot > 128'd524288) quot = 128'd524288;
      value = negative ? -longint'(quot) : longint'(quot);
      if (value > 524287) value = 524287;
      if (value < -524288) value = -524288;
      return tbw_pkg::W_WEIGHT'(value);
   endfunction

   // Predicts the response for one sample.
   function automatic tbw_pkg::rsp_type predict_weights(tbw_pkg::req_type s);
      tbw_pkg::rsp_type r;
      longint  x0, y0, x1, y1, x2, y2, px, py, area, n0, n1, n2;
      x0 = s.v0_x; y0 = s.v0_y; x1 = s.v1_x; y1 = s.v1_y;
      x2 = s.v2_x; y2 = s.v2_y; px = s.point_x; py = s.point_y;
      r = '0;
      if (px == x0 && py == y0) begin
         r.weight_zero = tbw_pkg::WEIGHT_UNIT;
      end else begin
         area = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
         if (area == 0) begin
            r.degenerate = 1'b1;
         end else begin
            n0 = (x1 - px) * (y2 - py) - (x2 - px) * (y1 - py);
            n1 = (px - x0) * (y2 - y0) - (x2 - x0) * (py - y0);
            n2 = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
            r.weight_zero = weight_ratio(n0, area);
            r.weight_one  = weight_ratio(n1, area);
            r.weight_two  = weight_ratio(n2, area);
         end
      end
      return r;
   endfunction

   // Cycle counter and timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response checker: compares each transfer with the oldest expectation.
   always @(posedge clock) begin
      tbw_pkg::rsp_type got;
      tbw_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.weight_zero = rsp_chan.weight_zero;
         got.weight_one  = rsp_chan.weight_one;
         got.weight_two  = rsp_chan.weight_two;
         got.degenerate  = rsp_chan.degenerate;
         if (expected_weights.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response %h", $time, got);
         end else begin
            want = expected_weights.pop_front();
            if (got.weight_zero !== want.weight_zero) begin
               error_count++;
               $display("%0t: weight_zero expected %0d actual %0d", $time,
                        want.weight_zero, got.weight_zero);
            end
            if (got.weight_one !== want.weight_one) begin
               error_count++;
               $display("%0t: weight_one expected %0d actual %0d", $time,
                        want.weight_one, got.weight_one);
            end
            if (got.weight_two !== want.weight_two) begin
               error_count++;
               $display("%0t: weight_two expected %0d actual %0d", $time,
                        want.weight_two, got.weight_two);
            end
            if (got.degenerate !== want.degenerate) begin
               error_count++;
               $display("%0t: degenerate expected %0b actual %0b", $time,
                        want.degenerate, got.degenerate);
            end
         end
      end
   end

   // Receiver side: random stall bursts, or a long counted hold-off when a test asks for one.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
         hold_off_cycles <= 0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_off_cycles <= HOLD_OFF_LENGTH - 1;
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= int'($urandom_range(0, 2));
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Sends one sample and waits for its transfer; the prediction is queued on acceptance.
   task automatic send_sample(tbw_pkg::req_type s);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.v0_x    <= s.v0_x;
      req_chan.v0_y    <= s.v0_y;
      req_chan.v1_x    <= s.v1_x;
      req_chan.v1_y    <= s.v1_y;
      req_chan.v2_x    <= s.v2_x;
      req_chan.v2_y    <= s.v2_y;
      req_chan.point_x <= s.point_x;
      req_chan.point_y <= s.point_y;
      do @(posedge clock); while (!req_chan.ready);
      expected_weights.insert(expected_weights.size(), predict_weights(s));
      @(negedge clock);
   endtask

   task automatic release_request();
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      release_request();
      while (expected_weights.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [tbw_pkg::W_COORD-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return tbw_pkg::W_COORD'($urandom);
         1: return tbw_pkg::W_COORD'($signed($urandom_range(0, 4000)) - 2000);
         2: return $urandom_range(0, 1) ? {1'b0, {(tbw_pkg::W_COORD-1){1'b1}}}
                                        : {1'b1, {(tbw_pkg::W_COORD-1){1'b0}}};
         default: return tbw_pkg::W_COORD'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   function automatic tbw_pkg::req_type random_sample();
      tbw_pkg::req_type s;
      s.v0_x = rand_coord(); s.v0_y = rand_coord();
      s.v1_x = rand_coord(); s.v1_y = rand_coord();
      s.v2_x = rand_coord(); s.v2_y = rand_coord();
      s.point_x = rand_coord(); s.point_y = rand_coord();
      case ($urandom_range(0, 9))
         0: begin
            s.point_x = s.v0_x;
            s.point_y = s.v0_y;
         end
         1: begin
            // Collinear vertices give a zero-area triangle.
            s.v1_x = s.v0_x; s.v2_x = s.v0_x;
         end
         2: begin
            s.v2_x = s.v1_x; s.v2_y = s.v1_y;
         end
         default: ;
      endcase
      return s;
   endfunction

   // Directed corners: vertex hit, zero area, saturation, extremes of the fields.
   task automatic test_directed();
      tbw_pkg::req_type s;
      logic signed [tbw_pkg::W_COORD-1:0] cmax, cmin;
      cmax = {1'b0, {(tbw_pkg::W_COORD-1){1'b1}}};
      cmin = {1'b1, {(tbw_pkg::W_COORD-1){1'b0}}};
      s = '{0, 0, 256, 0, 0, 256, 64, 64};
      send_sample(s);
      s = '{0, 0, 256, 0, 0, 256, 0, 0};
      send_sample(s);
      s = '{5, 5, 5, 5, 5, 5, 5, 5};
      send_sample(s);
      s = '{5, 5, 5, 5, 5, 5, 7, 9};
      send_sample(s);
      s = '{0, 0, 10, 10, 20, 20, 3, 1};
      send_sample(s);
      s = '{0, 0, 1, 0, 0, 1, cmax, cmax};
      send_sample(s);
      s = '{0, 0, 1, 0, 0, 1, cmin, cmin};
      send_sample(s);
      s = '{cmin, cmin, cmax, cmin, cmin, cmax, cmax, cmax};
      send_sample(s);
      s = '{cmax, cmax, cmin, cmax, cmax, cmin, cmin, cmin};
      send_sample(s);
      s = '{cmin, cmax, cmax, cmin, cmax, cmax, 0, 0};
      send_sample(s);
      s = '{0, 0, 2, 0, 0, 2, 1, 0};
      send_sample(s);
      s = '{0, 0, 3, 0, 0, 3, 1, 1};
      send_sample(s);
      s = '{-1, -1, -1, -1, -1, -1, -1, -1};
      send_sample(s);
      s = '{0, 0, 0, 256, 256, 0, 100, 30};
      send_sample(s);
      s = '{cmax, 0, 0, cmax, cmin, cmin, 1, 1};
      send_sample(s);
      wait_for_drain();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_sample(random_sample());
   endtask

   // Long receiver hold-off while the sender keeps offering, so the input backs up.
   task automatic test_backpressure();
      hold_off_requests++;
      for (int i = 0; i < 60; i++) send_sample(random_sample());
      wait_for_drain();
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.v0_x    = '0;
      req_chan.v0_y    = '0;
      req_chan.v1_x    = '0;
      req_chan.v1_y    = '0;
      req_chan.v2_x    = '0;
      req_chan.v2_y    = '0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(700);
      // The sender pauses here until every expected response has come.
      wait_for_drain();
      test_backpressure();
      test_random(500);
      // Last part of the run with no idling on either side.
      idle_enable = 1'b0;
      test_random(240);
      wait_for_drain();
      repeat (2 * tbw_tb_pkg::PIPE_LATENCY) @(negedge clock);

      if (error_count == 0 && expected_weights.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
